FILE: design/dttw_pkg.sv
package dttw_pkg;

  // Structure block tokens.
  localparam logic [31:0] TK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TK_END        = 32'h0000_0009;

  // Configuration register indexes (address bit 2).
  localparam logic REG_STRUCT_BYTES  = 1'b0;
  localparam logic REG_STRINGS_BYTES = 1'b1;

  // Parse phase of the walker.
  typedef enum logic [2:0] {
    PH_TOKEN = 3'd0,
    PH_NAME  = 3'd1,
    PH_PLEN  = 3'd2,
    PH_PNAME = 3'd3,
    PH_SKIP  = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERROR = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_NODE_BEGIN = 3'd0,
    EV_NODE_END   = 3'd1,
    EV_PROPERTY   = 3'd2,
    EV_TREE_END   = 3'd3,
    EV_ERROR      = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_NO_END_TOKEN  = 3'd1,
    ERR_UNTERM_NAME   = 3'd2,
    ERR_SHORT_PROP    = 3'd3,
    ERR_BAD_NAME_OFF  = 3'd4,
    ERR_VALUE_OVERRUN = 3'd5,
    ERR_UNKNOWN_TOKEN = 3'd6
  } error_code_t;

  // Register file contents seen by the parser.
  typedef struct packed {
    logic [31:0] struct_bytes;
    logic [31:0] strings_bytes;
  } cfg_t;

  // One parser result.
  typedef struct packed {
    logic              emit;
    event_kind_t       event_kind;
    error_code_t       error_code;
    logic signed [7:0] nest_depth;
    logic [31:0]       name_offset;
    logic [31:0]       body_offset;
    logic [31:0]       value_length;
  } result_t;

endpackage

FILE: design/dttw_cfg.sv
module dttw_cfg
  import dttw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [31:0] struct_bytes_r;
  logic [31:0] strings_bytes_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      struct_bytes_r  <= '0;
      strings_bytes_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_STRUCT_BYTES:  struct_bytes_r  <= cfg_pwdata;
        REG_STRINGS_BYTES: strings_bytes_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (cfg_paddr[2])
      REG_STRUCT_BYTES:  cfg_prdata = struct_bytes_r;
      REG_STRINGS_BYTES: cfg_prdata = strings_bytes_r;
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg.struct_bytes  = struct_bytes_r;
  assign cfg.strings_bytes = strings_bytes_r;

endmodule

FILE: design/dttw_parse.sv
module dttw_parse
  import dttw_pkg::*;
#(
  parameter int MAX_DEPTH = 127
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [31:0] blob_word,
  input  logic        first_word,
  input  cfg_t        cfg,
  output result_t     res
);

  localparam int DepthCapInt = (MAX_DEPTH < 127) ? MAX_DEPTH : 127;
  localparam logic signed [7:0] DepthCap = 8'(DepthCapInt);

  phase_t            phase_r, phase_nxt;
  logic [31:0]       offset_r, offset_nxt;
  logic signed [7:0] depth_r, depth_nxt;
  logic [31:0]       name_start_r, name_start_nxt;
  logic [31:0]       vlen_r, vlen_nxt;
  logic [29:0]       skip_r, skip_nxt;

  // A first word restarts the walk before it is parsed.
  phase_t            eff_phase;
  logic [31:0]       eff_off;
  logic signed [7:0] eff_depth;
  logic [31:0]       eff_nstart;
  logic [31:0]       eff_vlen;
  logic [29:0]       eff_skip;

  assign eff_phase  = first_word ? PH_TOKEN : phase_r;
  assign eff_off    = first_word ? 32'd0 : offset_r;
  assign eff_depth  = first_word ? -8'sd1 : depth_r;
  assign eff_nstart = first_word ? 32'd0 : name_start_r;
  assign eff_vlen   = first_word ? 32'd0 : vlen_r;
  assign eff_skip   = first_word ? 30'd0 : skip_r;

  // Bound checks, each a wide compare, some after a wide add.
  logic        tok_oob;
  logic        prop_short;
  logic [32:0] here4;
  logic [32:0] padded;
  logic [33:0] val_end;
  logic        val_over;
  logic        bad_name_off;
  logic [29:0] skip_new;
  logic [29:0] skip_dec;

  assign tok_oob      = eff_off >= cfg.struct_bytes;
  assign prop_short   = ({1'b0, eff_off} + 33'd12) > {1'b0, cfg.struct_bytes};
  assign here4        = {1'b0, eff_off} + 33'd4;
  assign padded       = ({1'b0, eff_vlen} + 33'd3) & ~33'd3;
  assign val_end      = {1'b0, here4} + {1'b0, padded};
  assign val_over     = val_end > {2'b00, cfg.struct_bytes};
  assign bad_name_off = blob_word >= cfg.strings_bytes;
  assign skip_new     = padded[31:2];
  assign skip_dec     = (eff_skip != 30'd0) ? eff_skip - 30'd1 : eff_skip;

  // Name scan: bytes in address order, bound checked before the NUL test.
  logic name_hit;
  logic name_err;

  always_comb begin
    logic        found;
    logic [32:0] pos;
    found    = 1'b0;
    name_hit = 1'b0;
    name_err = 1'b0;
    pos      = '0;
    for (int b = 0; b < 4; b++) begin
      pos = {1'b0, eff_off} + 33'(b);
      if (!found) begin
        if (pos >= {1'b0, cfg.struct_bytes}) begin
          name_err = 1'b1;
          found    = 1'b1;
        end else if (blob_word[31 - 8*b -: 8] == 8'h00) begin
          name_hit = 1'b1;
          found    = 1'b1;
        end
      end
    end
  end

  // Depth moves, saturating at the cap and at minus one.
  logic signed [7:0] depth_up;
  logic signed [7:0] depth_dn;

  assign depth_up = (eff_depth < DepthCap) ? eff_depth + 8'sd1 : eff_depth;
  assign depth_dn = (eff_depth > -8'sd1) ? eff_depth - 8'sd1 : eff_depth;

  // Next phase.
  always_comb begin
    phase_nxt = eff_phase;
    unique case (eff_phase)
      PH_TOKEN: begin
        if (tok_oob) begin
          phase_nxt = PH_ERROR;
        end else begin
          unique case (blob_word)
            TK_BEGIN_NODE: phase_nxt = PH_NAME;
            TK_PROP:       phase_nxt = prop_short ? PH_ERROR : PH_PLEN;
            TK_END_NODE:   phase_nxt = PH_TOKEN;
            TK_NOP:        phase_nxt = PH_TOKEN;
            TK_END:        phase_nxt = PH_DONE;
            default:       phase_nxt = PH_ERROR;
          endcase
        end
      end
      PH_NAME: begin
        if (name_err) begin
          phase_nxt = PH_ERROR;
        end else if (name_hit) begin
          phase_nxt = PH_TOKEN;
        end
      end
      PH_PLEN: phase_nxt = PH_PNAME;
      PH_PNAME: begin
        if (bad_name_off || val_over) begin
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = (skip_new != 30'd0) ? PH_SKIP : PH_TOKEN;
        end
      end
      PH_SKIP:  phase_nxt = (skip_dec == 30'd0) ? PH_TOKEN : PH_SKIP;
      PH_DONE:  phase_nxt = PH_DONE;
      PH_ERROR: phase_nxt = PH_ERROR;
      default:  phase_nxt = PH_ERROR;
    endcase
  end

  // Result and held data.
  always_comb begin
    res            = '0;
    res.event_kind = EV_NODE_BEGIN;
    res.error_code = ERR_NONE;
    res.nest_depth = eff_depth;
    depth_nxt      = eff_depth;
    name_start_nxt = eff_nstart;
    vlen_nxt       = eff_vlen;
    skip_nxt       = eff_skip;
    unique case (eff_phase)
      PH_TOKEN: begin
        if (tok_oob) begin
          res.emit        = 1'b1;
          res.event_kind  = EV_ERROR;
          res.error_code  = ERR_NO_END_TOKEN;
          res.body_offset = eff_off;
        end else begin
          unique case (blob_word)
            TK_BEGIN_NODE: name_start_nxt = here4[31:0];
            TK_PROP: begin
              if (prop_short) begin
                res.emit        = 1'b1;
                res.event_kind  = EV_ERROR;
                res.error_code  = ERR_SHORT_PROP;
                res.body_offset = eff_off;
              end
            end
            TK_END_NODE: begin
              depth_nxt      = depth_dn;
              res.emit       = 1'b1;
              res.event_kind = EV_NODE_END;
              res.nest_depth = depth_dn;
            end
            TK_NOP: ;
            TK_END: begin
              res.emit       = 1'b1;
              res.event_kind = EV_TREE_END;
            end
            default: begin
              res.emit        = 1'b1;
              res.event_kind  = EV_ERROR;
              res.error_code  = ERR_UNKNOWN_TOKEN;
              res.body_offset = eff_off;
            end
          endcase
        end
      end
      PH_NAME: begin
        if (name_err) begin
          res.emit        = 1'b1;
          res.event_kind  = EV_ERROR;
          res.error_code  = ERR_UNTERM_NAME;
          res.body_offset = eff_off;
        end else if (name_hit) begin
          depth_nxt       = depth_up;
          res.emit        = 1'b1;
          res.event_kind  = EV_NODE_BEGIN;
          res.nest_depth  = depth_up;
          res.name_offset = eff_nstart;
          res.body_offset = here4[31:0];
        end
      end
      PH_PLEN: vlen_nxt = blob_word;
      PH_PNAME: begin
        res.emit = 1'b1;
        if (bad_name_off) begin
          res.event_kind  = EV_ERROR;
          res.error_code  = ERR_BAD_NAME_OFF;
          res.body_offset = eff_off;
        end else if (val_over) begin
          res.event_kind  = EV_ERROR;
          res.error_code  = ERR_VALUE_OVERRUN;
          res.body_offset = eff_off;
        end else begin
          skip_nxt         = skip_new;
          res.event_kind   = EV_PROPERTY;
          res.name_offset  = blob_word;
          res.body_offset  = here4[31:0];
          res.value_length = eff_vlen;
        end
      end
      PH_SKIP:  skip_nxt = skip_dec;
      PH_DONE:  ;
      PH_ERROR: ;
      default:  ;
    endcase
  end

  // Byte offset of the next word, saturating at the top.
  assign offset_nxt = (eff_off > 32'hFFFF_FFFB) ? 32'hFFFF_FFFF : eff_off + 32'd4;

  // Walker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TOKEN;
      offset_r     <= '0;
      depth_r      <= -8'sd1;
      name_start_r <= '0;
      vlen_r       <= '0;
      skip_r       <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      offset_r     <= offset_nxt;
      depth_r      <= depth_nxt;
      name_start_r <= name_start_nxt;
      vlen_r       <= vlen_nxt;
      skip_r       <= skip_nxt;
    end
  end

endmodule

FILE: design/device_tree_token_walker.sv
// Device tree token walker. Takes the structure block of a flattened device
// tree one big-endian word per transfer (first byte in bits 31:24) and emits
// node begin, node end, property, tree end and error events with byte offsets
// into the structure and strings blocks. The walker accepts one word in every
// clock cycle unless a stalled result backs up the input; each word passes
// through an input register, combinational parse logic against the walker
// state, and a result register. A stalled result holds at most one further
// word in the input register. Set struct_bytes and strings_bytes before
// streaming, and mark the first word of each block with in_tuser. After an
// error or the end token the walker ignores words until the next first
// word. There is no clearing pass after reset.
module device_tree_token_walker
  import dttw_pkg::*;
#(
  parameter int MAX_DEPTH = 127
)
(
  input  logic         clk,
  input  logic         rst_n,
  // Configuration port.
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  // Word input.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] blob_word
  input  logic [0:0]   in_tuser,   // [0] first_word
  // Event output.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] error_code, [10:3] nest_depth, [42:11] name_offset,
  // [74:43] body_offset, [106:75] value_length, [111:107] zero
  output logic [111:0] out_tdata,
  output logic [2:0]   out_tuser   // [2:0] event_kind
);

  cfg_t    cfg;
  result_t res;

  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        s1_first_r;
  logic        advance;

  logic        out_valid_r;
  result_t     out_res_r;

  dttw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The held word is parsed when the result register can take its event.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_word_r  <= in_tdata;
      s1_first_r <= in_tuser[0];
    end
  end

  dttw_parse #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .blob_word  (s1_word_r),
    .first_word (s1_first_r),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.event_kind;
  assign out_tdata  = {5'd0, out_res_r.value_length, out_res_r.body_offset,
                       out_res_r.name_offset, out_res_r.nest_depth,
                       out_res_r.error_code};

endmodule

FILE: design/dttw_checker.sv
module dttw_checker
  import dttw_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         cfg_psel,
  input logic         cfg_penable,
  input logic         cfg_pwrite,
  input logic [2:0]   cfg_paddr,
  input logic [31:0]  cfg_pwdata,
  input logic [31:0]  cfg_prdata,
  input logic         cfg_pready,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [31:0]  in_tdata,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [2:0]   out_tuser
);

  // A stalled event holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("event changed while stalled");

  // The input only backs up when the output is stalled.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // Error events, and only they, carry an error code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == EV_ERROR) == (out_tdata[2:0] != ERR_NONE)))
    else $error("error code does not match event kind");

  // Only property events carry a value length.
  a_vlen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_PROPERTY |-> out_tdata[106:75] == 32'd0)
    else $error("value length on a non-property event");

  // Node end and tree end carry no offsets.
  a_end_offs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_NODE_END || out_tuser == EV_TREE_END) |->
      out_tdata[74:11] == 64'd0)
    else $error("offsets on an end event");

endmodule

bind device_tree_token_walker dttw_checker u_dttw_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dttw_pkg::*;

  // One expected walker event, in the field order of the result transfer.
  typedef struct packed {
    event_kind_t       kind;
    error_code_t       code;
    logic signed [7:0] depth;
    logic [31:0]       noff;
    logic [31:0]       boff;
    logic [31:0]       vlen;
  } walk_event_t;

  typedef enum bit {CHECK_MODEL, CHECK_TYPED} row_check_t;

  // One directed stimulus row; reconf rewrites both size registers first.
  typedef struct packed {
    bit          reconf;
    logic [31:0] sb;
    logic [31:0] strb;
    logic [31:0] word;
    bit          first;
    row_check_t  chk;
    walk_event_t ev;
  } stim_row_t;

  localparam int          NUM_ROWS    = 30;
  localparam int          NUM_PHASES  = 6;
  localparam int          SETTLE      = 8;
  localparam int          CYCLE_LIMIT = 100000;
  localparam walk_event_t NO_EVENT    = '0;

  // Size settings and word budgets of the random phases.
  localparam logic [31:0] STRUCT_SIZES  [NUM_PHASES] =
    '{32'hFFFF_FFFF, 32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd160, 32'd400};
  localparam logic [31:0] STRINGS_SIZES [NUM_PHASES] =
    '{32'hFFFF_FFFF, 32'd200, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd48};
  localparam int WORD_BUDGET [NUM_PHASES] = '{100, 50, 30, 40, 50, 50};

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;    // [31:0] blob_word
  logic [0:0]   in_tuser;    // [0] first_word
  logic         out_tvalid;
  logic         out_tready;
  // [2:0] error_code, [10:3] nest_depth, [42:11] name_offset,
  // [74:43] body_offset, [106:75] value_length, [111:107] zero
  logic [111:0] out_tdata;
  logic [2:0]   out_tuser;   // [2:0] event_kind

  // Walker state and register copies of the predictor.
  phase_t            w_phase;
  logic [31:0]       w_offset;
  logic signed [7:0] w_depth;
  logic [31:0]       w_name_start;
  logic [31:0]       w_vlen;
  logic [29:0]       w_skip;
  logic [31:0]       cfg_struct_bytes;
  logic [31:0]       cfg_strings_bytes;

  walk_event_t pending_events [$];
  stim_row_t   dir_rows [NUM_ROWS];
  int          mismatch_count;
  int          cycle_count;
  int          words_sent;
  int          in_idle_pct;
  int          out_idle_pct;
  bit          next_first;

  device_tree_token_walker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Event with the depth as it stands after the current word.
  function automatic walk_event_t make_event(event_kind_t k, error_code_t c,
                                             logic [31:0] n, logic [31:0] b,
                                             logic [31:0] v);
    make_event = '{k, c, w_depth, n, b, v};
  endfunction

  // Advance the predicted walker by one word and return the event it causes.
  task automatic walk_word(input logic [31:0] w, input bit f,
                           output bit hit, output walk_event_t ev);
    logic [63:0] here;
    logic [63:0] sb64;
    logic [63:0] voff;
    logic [63:0] padded;
    bit          found;
    hit = 1'b0;
    ev = NO_EVENT;
    found = 1'b0;
    if (f) begin
      w_phase = PH_TOKEN;
      w_offset = '0;
      w_depth = -8'sd1;
      w_name_start = '0;
      w_vlen = '0;
      w_skip = '0;
    end
    here = {32'd0, w_offset};
    sb64 = {32'd0, cfg_struct_bytes};
    case (w_phase)
      PH_TOKEN: begin
        if (here >= sb64) begin
          w_phase = PH_ERROR;
          hit = 1'b1;
          ev = make_event(EV_ERROR, ERR_NO_END_TOKEN, '0, w_offset, '0);
        end else begin
          case (w)
            TK_BEGIN_NODE: begin
              w_name_start = w_offset + 32'd4;
              w_phase = PH_NAME;
            end
            TK_PROP: begin
              if (here + 64'd12 > sb64) begin
                w_phase = PH_ERROR;
                hit = 1'b1;
                ev = make_event(EV_ERROR, ERR_SHORT_PROP, '0, w_offset, '0);
              end else begin
                w_phase = PH_PLEN;
              end
            end
            TK_END_NODE: begin
              if (w_depth > -8'sd1) w_depth = w_depth - 8'sd1;
              hit = 1'b1;
              ev = make_event(EV_NODE_END, ERR_NONE, '0, '0, '0);
            end
            TK_NOP: begin
            end
            TK_END: begin
              w_phase = PH_DONE;
              hit = 1'b1;
              ev = make_event(EV_TREE_END, ERR_NONE, '0, '0, '0);
            end
            default: begin
              w_phase = PH_ERROR;
              hit = 1'b1;
              ev = make_event(EV_ERROR, ERR_UNKNOWN_TOKEN, '0, w_offset, '0);
            end
          endcase
        end
      end
      // Name bytes are checked against the bound before the NUL test.
      PH_NAME: begin
        for (int b = 0; b < 4 && !found; b++) begin
          if (here + 64'(b) >= sb64) begin
            found = 1'b1;
            w_phase = PH_ERROR;
            hit = 1'b1;
            ev = make_event(EV_ERROR, ERR_UNTERM_NAME, '0, w_offset, '0);
          end else if (w[31-8*b -: 8] == 8'h00) begin
            found = 1'b1;
            if (w_depth < 8'sd127) w_depth = w_depth + 8'sd1;
            w_phase = PH_TOKEN;
            hit = 1'b1;
            ev = make_event(EV_NODE_BEGIN, ERR_NONE, w_name_start,
                            w_offset + 32'd4, '0);
          end
        end
      end
      PH_PLEN: begin
        w_vlen = w;
        w_phase = PH_PNAME;
      end
      PH_PNAME: begin
        voff = here + 64'd4;
        padded = ({32'd0, w_vlen} + 64'd3) & ~64'd3;
        hit = 1'b1;
        if (w >= cfg_strings_bytes) begin
          w_phase = PH_ERROR;
          ev = make_event(EV_ERROR, ERR_BAD_NAME_OFF, '0, w_offset, '0);
        end else if (voff + padded > sb64) begin
          w_phase = PH_ERROR;
          ev = make_event(EV_ERROR, ERR_VALUE_OVERRUN, '0, w_offset, '0);
        end else begin
          w_skip = padded[31:2];
          if (w_skip != 0) w_phase = PH_SKIP;
          else w_phase = PH_TOKEN;
          ev = make_event(EV_PROPERTY, ERR_NONE, w, voff[31:0], w_vlen);
        end
      end
      PH_SKIP: begin
        if (w_skip != 0) w_skip = w_skip - 30'd1;
        if (w_skip == 0) w_phase = PH_TOKEN;
      end
      default: begin
      end
    endcase
    // The byte offset saturates instead of wrapping.
    if (w_offset > 32'hFFFF_FFFB) w_offset = 32'hFFFF_FFFF;
    else w_offset = w_offset + 32'd4;
  endtask

  // Offer one word, with random idle cycles first, and predict it on transfer.
  // The valid stays high after the transfer; the caller lowers or reuses it.
  task automatic send_word(input logic [31:0] w, input bit f,
                           output bit hit, output walk_event_t ev);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= f;
    do @(posedge clk); while (in_tready !== 1'b1);
    walk_word(w, f, hit, ev);
  endtask

  task automatic put_word(input logic [31:0] w);
    bit          hit;
    walk_event_t ev;
    send_word(w, next_first, hit, ev);
    next_first = 1'b0;
    words_sent++;
    if (hit) pending_events.push_back(ev);
  endtask

  // Stop the input and wait until every expected event has arrived.
  task automatic drain_events();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic cfg_write(input logic idx, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (idx == REG_STRUCT_BYTES) cfg_struct_bytes = data;
    else cfg_strings_bytes = data;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== data) begin
      $error("cfg_prdata: expected %h, got %h", data, cfg_prdata);
      mismatch_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] sb, input logic [31:0] strb);
    cfg_write(REG_STRUCT_BYTES, sb);
    cfg_write(REG_STRINGS_BYTES, strb);
  endtask

  // Node name: up to nine nonzero bytes, a NUL, then random padding bytes.
  task automatic put_name();
    int          nb;
    int          nw;
    logic [31:0] w;
    logic [7:0]  c;
    nb = $urandom_range(0, 9);
    nw = nb / 4 + 1;
    w = '0;
    for (int i = 0; i < nw * 4; i++) begin
      if (i < nb) c = 8'($urandom_range(1, 255));
      else if (i == nb) c = 8'h00;
      else c = 8'($urandom_range(0, 255));
      w = {w[23:0], c};
      if (i % 4 == 3) put_word(w);
    end
  endtask

  // One structure block with random content. A deep block nests past the
  // depth cap first. Some blocks are cut off, and stray words may follow.
  task automatic gen_frame(input bit deep);
    int          n_tok;
    int          open;
    int          r;
    logic [31:0] len;
    next_first = 1'b1;
    n_tok = $urandom_range(1, 12);
    open = 0;
    if (deep) begin
      repeat (135) begin
        put_word(TK_BEGIN_NODE);
        put_name();
        open++;
      end
    end
    repeat (n_tok) begin
      r = $urandom_range(0, 99);
      if (open == 0 || (r < 25 && open < 4)) begin
        put_word(TK_BEGIN_NODE);
        put_name();
        open++;
      end else if (r < 60) begin
        put_word(TK_PROP);
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(0, 12);
        else if (r < 92) len = $urandom_range(13, 64);
        else len = 32'hFFFF_FFF8 + $urandom_range(0, 7);
        put_word(len);
        if (cfg_strings_bytes != 0 && $urandom_range(0, 9) != 0)
          put_word($urandom_range(0, cfg_strings_bytes - 1));
        else
          put_word($urandom);
        if (len <= 64) repeat ((len + 3) / 4) put_word($urandom);
      end else if (r < 80) begin
        put_word(TK_END_NODE);
        open--;
      end else if (r < 92) begin
        put_word(TK_NOP);
      end else begin
        put_word($urandom);
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      repeat (open) put_word(TK_END_NODE);
      put_word(TK_END);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        next_first = ($urandom_range(0, 3) == 0);
        put_word($urandom);
      end
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Compare each result transfer with the oldest expected event.
  always @(posedge clk) begin
    walk_event_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_events.size() == 0) begin
        $error("event_kind: expected no event, got %0d", out_tuser);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_tuser !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[2:0] !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, out_tdata[2:0]);
          mismatch_count++;
        end
        if (out_tdata[10:3] !== want.depth) begin
          $error("nest_depth: expected %0d, got %0d", want.depth,
                 $signed(out_tdata[10:3]));
          mismatch_count++;
        end
        if (out_tdata[42:11] !== want.noff) begin
          $error("name_offset: expected %h, got %h", want.noff, out_tdata[42:11]);
          mismatch_count++;
        end
        if (out_tdata[74:43] !== want.boff) begin
          $error("body_offset: expected %h, got %h", want.boff, out_tdata[74:43]);
          mismatch_count++;
        end
        if (out_tdata[106:75] !== want.vlen) begin
          $error("value_length: expected %h, got %h", want.vlen,
                 out_tdata[106:75]);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit          hit;
    walk_event_t ev;
    stim_row_t   row;

    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    mismatch_count = 0;
    words_sent = 0;
    next_first = 1'b0;
    in_idle_pct = 17;
    out_idle_pct = 47;
    cfg_struct_bytes = '0;
    cfg_strings_bytes = '0;
    w_phase = PH_TOKEN;
    w_offset = '0;
    w_depth = -8'sd1;
    w_name_start = '0;
    w_vlen = '0;
    w_skip = '0;

    // Directed rows. The first runs on the reset sizes of zero; the main
    // block uses a 96 byte structure and a 32 byte strings block.
    dir_rows = '{
      '{1'b0, 32'd0, 32'd0, TK_BEGIN_NODE, 1'b1, CHECK_TYPED,
        '{EV_ERROR, ERR_NO_END_TOKEN, -8'sd1, 32'd0, 32'd0, 32'd0}},
      '{1'b1, 32'd96, 32'd32, TK_NOP, 1'b1, CHECK_MODEL, NO_EVENT},
      // Node end with no open node keeps the depth at minus one.
      '{1'b0, 32'd0, 32'd0, TK_END_NODE, 1'b0, CHECK_TYPED,
        '{EV_NODE_END, ERR_NONE, -8'sd1, 32'd0, 32'd0, 32'd0}},
      '{1'b0, 32'd0, 32'd0, TK_BEGIN_NODE, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'h0000_0000, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, TK_PROP, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'd4, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'd31, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, TK_BEGIN_NODE, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'h6162_6364, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'h6566_00FF, 1'b0, CHECK_MODEL, NO_EVENT},
      // Property with an empty value.
      '{1'b0, 32'd0, 32'd0, TK_PROP, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, TK_END_NODE, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, TK_END_NODE, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, TK_END, 1'b0, CHECK_TYPED,
        '{EV_TREE_END, ERR_NONE, -8'sd1, 32'd0, 32'd0, 32'd0}},
      // Ignored after the end token.
      '{1'b0, 32'd0, 32'd0, 32'h1234_5678, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'hDEAD_BEEF, 1'b1, CHECK_TYPED,
        '{EV_ERROR, ERR_UNKNOWN_TOKEN, -8'sd1, 32'd0, 32'd0, 32'd0}},
      // Name offset equal to the strings size.
      '{1'b0, 32'd0, 32'd0, TK_PROP, 1'b1, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'd32, 1'b0, CHECK_MODEL, NO_EVENT},
      // Value running past the structure block.
      '{1'b0, 32'd0, 32'd0, TK_PROP, 1'b1, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFF0, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, CHECK_MODEL, NO_EVENT},
      // An 8 byte structure block: short property header, then a name
      // that runs off the end.
      '{1'b1, 32'd8, 32'hFFFF_FFFF, TK_PROP, 1'b1, CHECK_TYPED,
        '{EV_ERROR, ERR_SHORT_PROP, -8'sd1, 32'd0, 32'd0, 32'd0}},
      '{1'b0, 32'd0, 32'd0, TK_BEGIN_NODE, 1'b1, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'h4141_4141, 1'b0, CHECK_MODEL, NO_EVENT},
      '{1'b0, 32'd0, 32'd0, 32'h4141_4141, 1'b0, CHECK_TYPED,
        '{EV_ERROR, ERR_UNTERM_NAME, -8'sd1, 32'd0, 32'd8, 32'd0}}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.reconf) begin
        drain_events();
        set_limits(row.sb, row.strb);
      end
      send_word(row.word, row.first, hit, ev);
      if (row.chk == CHECK_TYPED) pending_events.push_back(row.ev);
      else if (hit) pending_events.push_back(ev);
    end
    drain_events();

    // Random phases: two per idling profile, each with its own sizes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin in_idle_pct = 17; out_idle_pct = 47; end
        1: begin in_idle_pct = 47; out_idle_pct = 17; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      set_limits(STRUCT_SIZES[p], STRINGS_SIZES[p]);
      words_sent = 0;
      if (p == 0) gen_frame(1'b1);
      while (words_sent < WORD_BUDGET[p]) gen_frame(1'b0);
      drain_events();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dttw_pkg.sv
design/dttw_cfg.sv
design/dttw_parse.sv
design/device_tree_token_walker.sv
design/dttw_checker.sv
tb/tb.sv
